// File: hdl/jeqf_pkg.sv
// Package for the escaped-quote filter: field widths, lane width and the
// per-lane result type. No dependencies.
package jeqf_pkg;

  localparam int FIELD_BITS = 32;
  localparam int LANE_BITS  = 8;

  typedef struct packed {
    logic [LANE_BITS-1:0] keep;
    logic                 odd_out;
  } lane_res_t;

endpackage

// File: hdl/jeqf_if.sv
// Valid/ready channel interfaces for the escaped-quote filter.
// Depends on jeqf_pkg.
interface jeqf_in_if;
  import jeqf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] quote_mask;
  logic [FIELD_BITS-1:0] backslash_mask;
  logic                  end_of_text;

  modport source (output valid, quote_mask, backslash_mask, end_of_text, input ready);
  modport sink   (input valid, quote_mask, backslash_mask, end_of_text, output ready);
endinterface

interface jeqf_out_if;
  import jeqf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] real_quote_mask;

  modport source (output valid, real_quote_mask, input ready);
  modport sink   (input valid, real_quote_mask, output ready);
endinterface

// File: hdl/json_escaped_quote_filter.sv
// Escaped-quote filter top level: one bitmap word per transfer in, one
// filtered quote mask per transfer out. Depends on jeqf_pkg, jeqf_if,
// jeqf_lane and jeqf_merge.
//
// The block takes one word every cycle while its skid buffer is empty, and
// returns each result from an output register backed by a one-entry skid
// buffer, so one more word is taken while a result waits. The word is split
// into lanes of eight characters that each resolve both possible incoming
// backslash parities; the merging stage then ripples the parity across the
// lanes and on into the carry register, and that chain sets the clock
// limit. Only the low WORD_BITS characters are examined; a backslash run
// that reaches the end of a word carries into the next word unless the
// word is flagged as the end of a text.
module json_escaped_quote_filter #(
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  jeqf_in_if.sink      words,
  jeqf_out_if.source   results
);
  import jeqf_pkg::*;

  localparam int NUM_LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;

  logic [WORD_BITS-1:0]           quotes_w;
  logic [WORD_BITS-1:0]           slashes_w;
  lane_res_t                      res_even [NUM_LANES];
  lane_res_t                      res_odd  [NUM_LANES];
  logic [NUM_LANES*LANE_BITS-1:0] keep_all;
  logic                           carry_out;
  logic [FIELD_BITS-1:0]          filtered;
  logic                           carry_odd_run;
  logic                           out_valid;
  logic [FIELD_BITS-1:0]          out_data;
  logic                           skid_valid;
  logic [FIELD_BITS-1:0]          skid_data;
  logic                           accept;
  logic                           out_free;

  assign quotes_w  = WORD_BITS'(words.quote_mask);
  assign slashes_w = WORD_BITS'(words.backslash_mask);

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int LW = (WORD_BITS - l * LANE_BITS) < LANE_BITS ?
                        (WORD_BITS - l * LANE_BITS) : LANE_BITS;
    jeqf_lane #(.WIDTH(LW)) u_lane (
      .quotes   (quotes_w[l*LANE_BITS +: LW]),
      .slashes  (slashes_w[l*LANE_BITS +: LW]),
      .res_even (res_even[l]),
      .res_odd  (res_odd[l])
    );
  end

  jeqf_merge #(.NUM_LANES(NUM_LANES)) u_merge (
    .res_even  (res_even),
    .res_odd   (res_odd),
    .carry_in  (carry_odd_run),
    .keep      (keep_all),
    .carry_out (carry_out)
  );

  assign filtered = FIELD_BITS'(keep_all[WORD_BITS-1:0]);

  assign words.ready             = ~skid_valid;
  assign accept                  = words.valid & ~skid_valid;
  assign out_free                = ~out_valid | results.ready;
  assign results.valid           = out_valid;
  assign results.real_quote_mask = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_odd_run <= 1'b0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (accept) begin
        carry_odd_run <= words.end_of_text ? 1'b0 : carry_out;
      end
      if (out_free) begin
        out_valid  <= skid_valid | accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : filtered;
    end else if (accept) begin
      skid_data <= filtered;
    end
  end

endmodule

// File: hdl/jeqf_lane.sv
// One lane of the filter: scans a slice of the word for both possible
// incoming run parities. Depends on jeqf_pkg.
module jeqf_lane #(
  parameter int WIDTH = 8
) (
  input  logic [WIDTH-1:0]  quotes,
  input  logic [WIDTH-1:0]  slashes,
  output jeqf_pkg::lane_res_t res_even,
  output jeqf_pkg::lane_res_t res_odd
);
  import jeqf_pkg::*;

  function automatic lane_res_t scan(input logic start, input logic [WIDTH-1:0] q,
                                     input logic [WIDTH-1:0] s);
    lane_res_t r;
    logic      odd;
    r   = '0;
    odd = start;
    for (int i = 0; i < WIDTH; i++) begin
      r.keep[i] = q[i] & ~odd;
      odd       = s[i] & ~odd;
    end
    r.odd_out = odd;
    return r;
  endfunction

  assign res_even = scan(1'b0, quotes, slashes);
  assign res_odd  = scan(1'b1, quotes, slashes);

endmodule

// File: hdl/jeqf_merge.sv
// Merging stage: ripples the run parity across lanes and picks each lane's
// matching result. Depends on jeqf_pkg.
module jeqf_merge #(
  parameter int NUM_LANES = 4
) (
  input  jeqf_pkg::lane_res_t                       res_even [NUM_LANES],
  input  jeqf_pkg::lane_res_t                       res_odd  [NUM_LANES],
  input  logic                                      carry_in,
  output logic [NUM_LANES*jeqf_pkg::LANE_BITS-1:0]  keep,
  output logic                                      carry_out
);
  import jeqf_pkg::*;

  always_comb begin
    logic odd;
    odd  = carry_in;
    keep = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (odd) begin
        keep[l*LANE_BITS +: LANE_BITS] = res_odd[l].keep;
        odd = res_odd[l].odd_out;
      end else begin
        keep[l*LANE_BITS +: LANE_BITS] = res_even[l].keep;
        odd = res_even[l].odd_out;
      end
    end
    carry_out = odd;
  end

endmodule

// File: hdl/jeqf_checker.sv
// Port-level checker for the escaped-quote filter and its bind statement.
// Depends on jeqf_pkg and json_escaped_quote_filter.
module jeqf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [jeqf_pkg::FIELD_BITS-1:0] quote_mask,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [jeqf_pkg::FIELD_BITS-1:0] real_quote_mask
);
  import jeqf_pkg::*;

  logic [1:0] pending;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(real_quote_mask))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown without a pending transfer");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !in_ready)
    else $error("input taken with both buffer entries full");

  a_subset: assert property (@(posedge clk) disable iff (rst)
    in_fire && !out_valid |=>
      out_valid && ((real_quote_mask & ~$past(quote_mask)) == '0))
    else $error("result holds a quote that was not in the input");

endmodule

bind json_escaped_quote_filter jeqf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (words.valid),
  .in_ready        (words.ready),
  .quote_mask      (words.quote_mask),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .real_quote_mask (results.real_quote_mask)
);
